@@ sv/riht_pkg.sv @@
`default_nettype none

package riht_pkg;

   // Fixed field widths
   localparam int SLOT_W    = 6;
   localparam int DEV_W     = 16;
   localparam int INO_W     = 32;
   localparam int COUNT_W   = 8;
   localparam int STATUS_W  = 4;
   localparam int START_W   = 31;
   localparam int POS_W     = 3;
   // Cell index width, wide enough for the largest table supported
   localparam int IDX_MAX_W = 10;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

   typedef enum logic [1:0] {
      CMD_GET  = 2'd0,
      CMD_PUT  = 2'd1,
      CMD_MARK = 2'd2,
      CMD_NONE = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_HIT         = 4'd0,
      STAT_LOADED      = 4'd1,
      STAT_FULL        = 4'd2,
      STAT_HELD        = 4'd3,
      STAT_FREED_CLEAN = 4'd4,
      STAT_FREED_WB    = 4'd5,
      STAT_SLOT_FREE   = 4'd6,
      STAT_MARKED      = 4'd7,
      STAT_SATURATED   = 4'd8
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_SCAN,
      ST_DECIDE,
      ST_EMIT
   } state_type;

   // Request held steady for the whole pass along the chain
   typedef struct packed {
      cmd_type           cmd;
      logic [DEV_W-1:0]  dev;
      logic [INO_W-1:0]  ino;
      logic [SLOT_W-1:0] slot;
   } query_type;

   // Search word handed from cell to cell
   typedef struct packed {
      logic                 valid;
      logic                 hit;
      logic [IDX_MAX_W-1:0] hit_idx;
      logic [COUNT_W-1:0]   cnt;
      logic [DEV_W-1:0]     dev;
      logic [INO_W-1:0]     ino;
      logic                 dirty;
      logic                 free_found;
      logic [IDX_MAX_W-1:0] free_idx;
   } token_type;

   // Update broadcast to all cells, taken by the one whose index matches
   typedef struct packed {
      logic                 valid;
      logic [IDX_MAX_W-1:0] idx;
      logic                 wr_count;
      logic [COUNT_W-1:0]   count;
      logic                 wr_key;
      logic [DEV_W-1:0]     dev;
      logic [INO_W-1:0]     ino;
      logic                 set_dirty;
      logic                 clr_dirty;
   } update_type;

endpackage

`default_nettype wire

@@ sv/riht_cell.sv @@
`default_nettype none

module riht_cell #(
   parameter int INDEX = 0
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire riht_pkg::query_type  query,
   input  wire riht_pkg::update_type upd,
   input  wire riht_pkg::token_type  tok_in,
   output      riht_pkg::token_type  tok_out
);
   import riht_pkg::*;

   localparam logic [IDX_MAX_W-1:0] CELL_IDX = IDX_MAX_W'(INDEX);

   logic [COUNT_W-1:0] count_ff;
   logic               dirty_ff;
   logic [DEV_W-1:0]   dev_ff;
   logic [INO_W-1:0]   ino_ff;
   logic               tok_valid_ff;
   token_type          tok_ff;
   token_type          tok_in_w;
   logic               held;
   logic               match;
   logic               mine;

   assign held = (count_ff != '0);
   assign mine = upd.valid && (upd.idx == CELL_IDX);

   // Compare this entry against the passing word
   always_comb begin
      if (query.cmd == CMD_GET) begin
         match = held && (dev_ff == query.dev) && (ino_ff == query.ino);
      end else begin
         match = held && ({{(IDX_MAX_W-SLOT_W){1'b0}}, query.slot} == CELL_IDX);
      end
   end

   // Claim the word on the first match and note the first free entry
   always_comb begin
      tok_in_w = tok_in;
      if (tok_in.valid && !tok_in.hit && match) begin
         tok_in_w.hit     = 1'b1;
         tok_in_w.hit_idx = CELL_IDX;
         tok_in_w.cnt     = count_ff;
         tok_in_w.dev     = dev_ff;
         tok_in_w.ino     = ino_ff;
         tok_in_w.dirty   = dirty_ff;
      end
      if (tok_in.valid && !tok_in.free_found && !held) begin
         tok_in_w.free_found = 1'b1;
         tok_in_w.free_idx   = CELL_IDX;
      end
   end

   // Control state of the entry and of the word slot
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         dirty_ff     <= 1'b0;
         tok_valid_ff <= 1'b0;
      end else begin
         tok_valid_ff <= tok_in.valid;
         if (mine && upd.wr_count) begin
            count_ff <= upd.count;
         end
         if (mine && upd.set_dirty) begin
            dirty_ff <= 1'b1;
         end else if (mine && upd.clr_dirty) begin
            dirty_ff <= 1'b0;
         end
      end
   end

   // Key and passing word payload
   always_ff @(posedge clock) begin
      tok_ff <= tok_in_w;
      if (mine && upd.wr_key) begin
         dev_ff <= upd.dev;
         ino_ff <= upd.ino;
      end
   end

   always_comb begin
      tok_out       = tok_ff;
      tok_out.valid = tok_valid_ff;
   end

endmodule

`default_nettype wire

@@ sv/refcounted_inode_handle_table.sv @@
`default_nettype none

// Channel | Direction | Handshake             | Word
// req     | in        | req_valid / req_ready | cmd, device_id, inode_number, handle_slot
// rsp     | out       | rsp_valid / rsp_ready | result_slot, status, device_out,
//         |           |                       | disk_block, inode_in_block, ref_count_out
// csr     | in        | csr_valid / csr_ready | table_start_block (always ready)
//
// One request is in work at a time. The search word walks the row of cells one
// entry per cycle, then the DECIDE state decides and updates the entry and the
// EMIT state loads the result register. Command 3 is taken and dropped without a
// search word. Reset is synchronous and clears every count and dirty mark
// at once; no clearing pass. A stalled result holds in its register and the next
// request is taken meanwhile; only its own result waits for the register to empty.
module refcounted_inode_handle_table #(
   parameter int TABLE_ENTRIES = 64
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_ready,
   input  wire logic [1:0]                    req_cmd,
   input  wire logic [riht_pkg::DEV_W-1:0]    req_device_id,
   input  wire logic [riht_pkg::INO_W-1:0]    req_inode_number,
   input  wire logic [riht_pkg::SLOT_W-1:0]   req_handle_slot,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   output      logic [riht_pkg::SLOT_W-1:0]   rsp_result_slot,
   output      logic [riht_pkg::STATUS_W-1:0] rsp_status,
   output      logic [riht_pkg::DEV_W-1:0]    rsp_device_out,
   output      logic [riht_pkg::INO_W-1:0]    rsp_disk_block,
   output      logic [riht_pkg::POS_W-1:0]    rsp_inode_in_block,
   output      logic [riht_pkg::COUNT_W-1:0]  rsp_ref_count_out,
   input  wire logic                          csr_valid,
   output      logic                          csr_ready,
   input  wire logic [riht_pkg::START_W-1:0]  csr_table_start_block
);
   import riht_pkg::*;

   state_type            state_ff, state_in;
   query_type            query_ff;
   logic [START_W-1:0]   start_ff;
   token_type            end_ff;
   token_type            chain [TABLE_ENTRIES+1];
   update_type           upd;

   logic [SLOT_W-1:0]    res_slot_ff, res_slot_in;
   status_type           res_status_ff, res_status_in;
   logic                 res_key_ff, res_key_in;
   logic [DEV_W-1:0]     res_dev_ff, res_dev_in;
   logic [INO_W-1:0]     res_ino_m1_ff;
   logic [INO_W-1:0]     res_ino_in;
   logic [COUNT_W-1:0]   res_count_ff, res_count_in;
   logic [COUNT_W-1:0]   cnt_dec;

   logic                 rsp_valid_ff;
   logic [SLOT_W-1:0]    rsp_slot_ff;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic [DEV_W-1:0]     rsp_dev_ff;
   logic [INO_W-1:0]     rsp_block_ff;
   logic [POS_W-1:0]     rsp_pos_ff;
   logic [COUNT_W-1:0]   rsp_count_ff;

   logic                 req_fire;
   logic                 emit_go;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign emit_go   = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);

   // Sequencer: start word, wait for it at the end of the row, decide, emit
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (cmd_type'(req_cmd) != CMD_NONE)) begin
               state_in = ST_START;
            end
         end
         ST_START: state_in = ST_SCAN;
         ST_SCAN: begin
            if (chain[TABLE_ENTRIES].valid) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: state_in = ST_EMIT;
         ST_EMIT: begin
            if (emit_go) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            start_ff <= csr_table_start_block;
         end
         if (emit_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Inject a fresh search word at the head of the row
   always_comb begin
      chain[0]       = '0;
      chain[0].valid = (state_ff == ST_START);
   end

   genvar gi;
   generate
      for (gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_cell
         riht_cell #(
            .INDEX(gi)
         ) u_cell (
            .clock  (clock),
            .reset  (reset),
            .query  (query_ff),
            .upd    (upd),
            .tok_in (chain[gi]),
            .tok_out(chain[gi+1])
         );
      end
   endgenerate

   // Work out status, result fields and the entry update from the finished word
   always_comb begin
      res_slot_in   = end_ff.hit_idx[SLOT_W-1:0];
      res_status_in = STAT_SLOT_FREE;
      res_key_in    = 1'b0;
      res_dev_in    = end_ff.dev;
      res_ino_in    = end_ff.ino;
      res_count_in  = '0;
      cnt_dec       = end_ff.cnt - 8'd1;
      upd           = '0;
      upd.idx       = end_ff.hit_idx;
      case (query_ff.cmd)
         CMD_GET: begin
            if (end_ff.hit) begin
               res_key_in = 1'b1;
               if (end_ff.cnt == COUNT_MAX) begin
                  res_status_in = STAT_SATURATED;
                  res_count_in  = end_ff.cnt;
               end else begin
                  res_status_in = STAT_HIT;
                  res_count_in  = end_ff.cnt + 8'd1;
                  upd.valid     = 1'b1;
                  upd.wr_count  = 1'b1;
                  upd.count     = end_ff.cnt + 8'd1;
               end
            end else if (end_ff.free_found) begin
               res_status_in = STAT_LOADED;
               res_slot_in   = end_ff.free_idx[SLOT_W-1:0];
               res_key_in    = 1'b1;
               res_dev_in    = query_ff.dev;
               res_ino_in    = query_ff.ino;
               res_count_in  = 8'd1;
               upd.valid     = 1'b1;
               upd.idx       = end_ff.free_idx;
               upd.wr_count  = 1'b1;
               upd.count     = 8'd1;
               upd.wr_key    = 1'b1;
               upd.dev       = query_ff.dev;
               upd.ino       = query_ff.ino;
               upd.clr_dirty = 1'b1;
            end else begin
               res_status_in = STAT_FULL;
               res_slot_in   = '0;
            end
         end
         CMD_PUT: begin
            if (!end_ff.hit) begin
               res_slot_in = query_ff.slot;
            end else begin
               res_key_in   = 1'b1;
               res_count_in = cnt_dec;
               upd.valid    = 1'b1;
               upd.wr_count = 1'b1;
               upd.count    = cnt_dec;
               if (cnt_dec == '0) begin
                  upd.clr_dirty = 1'b1;
                  res_status_in = end_ff.dirty ? STAT_FREED_WB : STAT_FREED_CLEAN;
               end else begin
                  res_status_in = STAT_HELD;
               end
            end
         end
         CMD_MARK: begin
            if (!end_ff.hit) begin
               res_slot_in = query_ff.slot;
            end else begin
               res_key_in    = 1'b1;
               res_status_in = STAT_MARKED;
               res_count_in  = end_ff.cnt;
               upd.valid     = 1'b1;
               upd.set_dirty = 1'b1;
            end
         end
         default: begin
            res_slot_in = query_ff.slot;
         end
      endcase
      upd.valid = upd.valid && (state_ff == ST_DECIDE);
   end

   // Payload registers: request, finished word, decision, result word
   always_ff @(posedge clock) begin
      if (req_fire) begin
         query_ff.cmd  <= cmd_type'(req_cmd);
         query_ff.dev  <= req_device_id;
         query_ff.ino  <= req_inode_number;
         query_ff.slot <= req_handle_slot;
      end
      if ((state_ff == ST_SCAN) && chain[TABLE_ENTRIES].valid) begin
         end_ff <= chain[TABLE_ENTRIES];
      end
      if (state_ff == ST_DECIDE) begin
         res_slot_ff   <= res_slot_in;
         res_status_ff <= res_status_in;
         res_key_ff    <= res_key_in;
         res_dev_ff    <= res_dev_in;
         res_ino_m1_ff <= res_ino_in - 32'd1;
         res_count_ff  <= res_count_in;
      end
      if (emit_go) begin
         rsp_slot_ff   <= res_slot_ff;
         rsp_status_ff <= res_status_ff;
         rsp_count_ff  <= res_count_ff;
         if (res_key_ff) begin
            rsp_dev_ff   <= res_dev_ff;
            rsp_block_ff <= {3'b000, res_ino_m1_ff[INO_W-1:POS_W]} + {1'b0, start_ff};
            rsp_pos_ff   <= res_ino_m1_ff[POS_W-1:0];
         end else begin
            rsp_dev_ff   <= '0;
            rsp_block_ff <= '0;
            rsp_pos_ff   <= '0;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_slot    = rsp_slot_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_device_out     = rsp_dev_ff;
   assign rsp_disk_block     = rsp_block_ff;
   assign rsp_inode_in_block = rsp_pos_ff;
   assign rsp_ref_count_out  = rsp_count_ff;

endmodule

`default_nettype wire

@@ bench/tb_refcounted_inode_handle_table.sv @@
`timescale 1ns / 1ps

module tb_refcounted_inode_handle_table;
   import riht_pkg::*;

   localparam int N_ENTRIES        = 64;
   localparam int INODES_PER_BLOCK = 8;
   localparam int CYCLE_LIMIT      = 1000000;
   // one search pass plus margin: cover any word still in flight
   localparam int SETTLE_CYCLES    = N_ENTRIES + 16;
   localparam int HOLD_CYCLES      = 400;
   localparam int QUIET_FROM       = 500;
   localparam int QUIET_TO         = 700;
   localparam int REPORT_LIMIT     = 10;

   typedef struct packed {
      logic [SLOT_W-1:0]  slot;
      status_type         status;
      logic [DEV_W-1:0]   dev;
      logic [INO_W-1:0]   block;
      logic [POS_W-1:0]   pos;
      logic [COUNT_W-1:0] count;
   } handle_answer_type;

   typedef enum {MIX_BALANCED, MIX_FILL, MIX_SATURATE, MIX_DRAIN} traffic_mix_type;

   // Mirror of the handle table: predicts each answer and holds those not yet seen
   class handle_table_mirror;
      bit [COUNT_W-1:0]  ref_cnt [N_ENTRIES];
      bit [DEV_W-1:0]    key_dev [N_ENTRIES];
      bit [INO_W-1:0]    key_ino [N_ENTRIES];
      bit                dirty   [N_ENTRIES];
      bit [START_W-1:0]  start_block;
      handle_answer_type awaited_answers [$];
      int unsigned       failures;

      function void set_start(bit [START_W-1:0] v);
         start_block = v;
      endfunction

      function handle_answer_type answer(int idx, status_type st, bit keyed,
                                         bit [DEV_W-1:0] d, bit [INO_W-1:0] n,
                                         bit [COUNT_W-1:0] c);
         handle_answer_type a;
         bit [INO_W-1:0] seq;
         // inode numbers count from 1; zero wraps round
         seq      = n - 1;
         a.slot   = SLOT_W'(idx);
         a.status = st;
         a.dev    = keyed ? d : '0;
         a.block  = keyed ? (seq / INODES_PER_BLOCK) + INO_W'(start_block) : '0;
         a.pos    = keyed ? POS_W'(seq % INODES_PER_BLOCK) : '0;
         a.count  = c;
         return a;
      endfunction

      function void apply_request(cmd_type c, bit [DEV_W-1:0] d, bit [INO_W-1:0] n,
                                  bit [SLOT_W-1:0] s);
         handle_answer_type a;
         int found;
         int i;
         int k;
         found = -1;
         k = int'(s);
         case (c)
            CMD_GET: begin
               // look for a held entry with the same key
               for (i = 0; i < N_ENTRIES; i++)
                  if (found < 0 && ref_cnt[i] != 0 && key_dev[i] == d && key_ino[i] == n)
                     found = i;
               if (found >= 0) begin
                  if (ref_cnt[found] == COUNT_MAX) begin
                     a = answer(found, STAT_SATURATED, 1'b1, d, n, COUNT_MAX);
                  end else begin
                     ref_cnt[found]++;
                     a = answer(found, STAT_HIT, 1'b1, d, n, ref_cnt[found]);
                  end
               end else begin
                  // miss: take the lowest free entry
                  for (i = 0; i < N_ENTRIES; i++)
                     if (found < 0 && ref_cnt[i] == 0)
                        found = i;
                  if (found >= 0) begin
                     ref_cnt[found] = COUNT_W'(1);
                     key_dev[found] = d;
                     key_ino[found] = n;
                     dirty[found]   = 1'b0;
                     a = answer(found, STAT_LOADED, 1'b1, d, n, COUNT_W'(1));
                  end else begin
                     a = answer(0, STAT_FULL, 1'b0, '0, '0, '0);
                  end
               end
            end
            CMD_NONE: return;
            default: begin
               if (k >= N_ENTRIES || ref_cnt[k] == 0) begin
                  a = answer(k, STAT_SLOT_FREE, 1'b0, '0, '0, '0);
               end else if (c == CMD_MARK) begin
                  dirty[k] = 1'b1;
                  a = answer(k, STAT_MARKED, 1'b1, key_dev[k], key_ino[k], ref_cnt[k]);
               end else begin
                  ref_cnt[k]--;
                  if (ref_cnt[k] != 0) begin
                     a = answer(k, STAT_HELD, 1'b1, key_dev[k], key_ino[k], ref_cnt[k]);
                  end else begin
                     // last reference gone: free the entry, drop the dirty mark
                     a = answer(k, dirty[k] ? STAT_FREED_WB : STAT_FREED_CLEAN, 1'b1,
                                key_dev[k], key_ino[k], '0);
                     dirty[k] = 1'b0;
                  end
               end
            end
         endcase
         awaited_answers.push_back(a);
      endfunction

      function int pick_held_slot();
         int held [$];
         int i;
         for (i = 0; i < N_ENTRIES; i++)
            if (ref_cnt[i] != 0)
               held.push_back(i);
         if (held.size() == 0)
            return -1;
         return held[$urandom_range(held.size() - 1)];
      endfunction

      function string describe(handle_answer_type a);
         return $sformatf("slot %0d status %0d dev %h block %h pos %0d count %0d",
                          a.slot, a.status, a.dev, a.block, a.pos, a.count);
      endfunction

      function void compare_answer(handle_answer_type got);
         handle_answer_type want;
         if (awaited_answers.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("ERROR: unexpected result: %s", describe(got));
            return;
         end
         want = awaited_answers.pop_front();
         if (got.slot !== want.slot || got.status !== want.status ||
             got.dev !== want.dev || got.block !== want.block ||
             got.pos !== want.pos || got.count !== want.count) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("ERROR: result mismatch at %0t\n  expected %s\n  actual   %s",
                        $time, describe(want), describe(got));
         end
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [1:0]          req_cmd = CMD_NONE;
   logic [DEV_W-1:0]    req_device_id = '0;
   logic [INO_W-1:0]    req_inode_number = '0;
   logic [SLOT_W-1:0]   req_handle_slot = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [SLOT_W-1:0]   rsp_result_slot;
   logic [STATUS_W-1:0] rsp_status;
   logic [DEV_W-1:0]    rsp_device_out;
   logic [INO_W-1:0]    rsp_disk_block;
   logic [POS_W-1:0]    rsp_inode_in_block;
   logic [COUNT_W-1:0]  rsp_ref_count_out;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [START_W-1:0]  csr_table_start_block = '0;

   handle_table_mirror mirror;
   handle_answer_type  got;
   int unsigned        cycle_count;
   int unsigned        req_accepted;
   int unsigned        answers_seen;
   int unsigned        hold_left;
   int unsigned        holds_done;
   logic [DEV_W-1:0]   pool_dev [4];
   logic [INO_W-1:0]   pool_ino [4];
   logic [DEV_W-1:0]   sat_dev;
   logic [INO_W-1:0]   sat_ino;

   refcounted_inode_handle_table #(
      .TABLE_ENTRIES(N_ENTRIES)
   ) i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_cmd               (req_cmd),
      .req_device_id         (req_device_id),
      .req_inode_number      (req_inode_number),
      .req_handle_slot       (req_handle_slot),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_result_slot       (rsp_result_slot),
      .rsp_status            (rsp_status),
      .rsp_device_out        (rsp_device_out),
      .rsp_disk_block        (rsp_disk_block),
      .rsp_inode_in_block    (rsp_inode_in_block),
      .rsp_ref_count_out     (rsp_ref_count_out),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_table_start_block (csr_table_start_block)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Abandon a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Take result words, with random stalls and two long hold-offs
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         got.slot   = rsp_result_slot;
         got.status = status_type'(rsp_status);
         got.dev    = rsp_device_out;
         got.block  = rsp_disk_block;
         got.pos    = rsp_inode_in_block;
         got.count  = rsp_ref_count_out;
         mirror.compare_answer(got);
         answers_seen++;
      end
      if (hold_left == 0 && holds_done < 2 &&
          answers_seen >= (holds_done == 0 ? 150 : 1100)) begin
         hold_left = HOLD_CYCLES;
         holds_done++;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= (answers_seen >= QUIET_FROM && answers_seen < QUIET_TO) ||
                      ($urandom_range(99) >= 9);
      end
   end

   // Offer one request word, hold it until taken, then predict its answer
   task automatic offer(input cmd_type c, input logic [DEV_W-1:0] d,
                        input logic [INO_W-1:0] n, input logic [SLOT_W-1:0] s);
      int gap;
      if (!(req_accepted >= QUIET_FROM && req_accepted < QUIET_TO) &&
          $urandom_range(99) < 9) begin
         gap = $urandom_range(1, N_ENTRIES + 8);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_cmd          <= c;
      req_device_id    <= d;
      req_inode_number <= n;
      req_handle_slot  <= s;
      do @(posedge clock); while (!req_ready);
      mirror.apply_request(c, d, n, s);
      req_accepted++;
   endtask

   // Drop valid, wait for every awaited answer, then let the block go quiet
   task automatic settle();
      req_valid <= 1'b0;
      while (mirror.awaited_answers.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_start(input logic [START_W-1:0] v);
      csr_valid             <= 1'b1;
      csr_table_start_block <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      mirror.set_start(v);
   endtask

   // Random traffic, mostly well-formed: pooled keys, puts and marks on held entries
   task automatic run_mix(input int items, input traffic_mix_type mix);
      cmd_type          c;
      logic [DEV_W-1:0] d;
      logic [INO_W-1:0] n;
      logic [SLOT_W-1:0] s;
      int r;
      int pick;
      int held;
      int get_pct;
      int mark_pct;
      int k;
      get_pct  = (mix == MIX_FILL) ? 85 : (mix == MIX_DRAIN) ? 25 : 50;
      mark_pct = (mix == MIX_FILL) ? 4 : (mix == MIX_DRAIN) ? 10 : 12;
      for (k = 0; k < items; k++) begin
         d = DEV_W'($urandom);
         n = $urandom;
         s = SLOT_W'($urandom_range(N_ENTRIES - 1));
         r = $urandom_range(99);
         if (mix == MIX_SATURATE) begin
            c = CMD_GET;
            d = sat_dev;
            n = sat_ino;
         end else if (r < 3) begin
            c = CMD_NONE;
         end else if (r < 3 + get_pct) begin
            c = CMD_GET;
            if (mix != MIX_FILL && $urandom_range(99) < 80) begin
               pick = $urandom_range(15);
               d = pool_dev[pick % 4];
               n = pool_ino[pick / 4];
            end
         end else begin
            c = (r < 3 + get_pct + mark_pct) ? CMD_MARK : CMD_PUT;
            held = mirror.pick_held_slot();
            if (held >= 0 && $urandom_range(99) < 85)
               s = held[SLOT_W-1:0];
         end
         offer(c, d, n, s);
      end
   endtask

   initial begin
      mirror = new;
      // keys that share a device or an inode number, one of them inode zero
      for (int i = 0; i < 4; i++) begin
         pool_dev[i] = DEV_W'($urandom);
         pool_ino[i] = $urandom;
      end
      pool_ino[3] = '0;
      sat_dev = DEV_W'($urandom);
      sat_ino = $urandom;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset table start, edge keys, dirty and clean release, free slots
      offer(CMD_GET,  16'h0000, 32'd1,         6'd0);
      offer(CMD_GET,  16'h0000, 32'd1,         6'd63);
      offer(CMD_GET,  16'hFFFF, 32'hFFFF_FFFF, 6'd0);
      offer(CMD_GET,  16'h0000, 32'd0,         6'd0);
      offer(CMD_NONE, 16'hFFFF, 32'hFFFF_FFFF, 6'd63);
      offer(CMD_MARK, 16'hFFFF, 32'hFFFF_FFFF, 6'd0);
      offer(CMD_PUT,  16'h0000, 32'd0,         6'd0);
      offer(CMD_PUT,  16'h0000, 32'd0,         6'd0);
      offer(CMD_PUT,  16'h0000, 32'd0,         6'd0);
      offer(CMD_MARK, 16'h0000, 32'd0,         6'd63);
      offer(CMD_PUT,  16'h0000, 32'd0,         6'd1);
      settle();

      // Directed: largest table start, block boundaries, near-miss keys
      write_start({START_W{1'b1}});
      offer(CMD_GET,  16'hFFFF, 32'hFFFF_FFFF, 6'd0);
      offer(CMD_GET,  16'h0001, 32'd8,         6'd0);
      offer(CMD_GET,  16'h0001, 32'd9,         6'd0);
      offer(CMD_GET,  16'h0002, 32'd8,         6'd0);
      offer(CMD_GET,  16'h0001, 32'd8,         6'd0);
      offer(CMD_MARK, 16'h0000, 32'd0,         6'd2);
      offer(CMD_MARK, 16'h0000, 32'd0,         6'd2);
      offer(CMD_PUT,  16'h0000, 32'd0,         6'd2);
      offer(CMD_GET,  16'h0000, 32'd0,         6'd0);
      offer(CMD_NONE, 16'h0000, 32'd0,         6'd0);
      settle();

      // Random phases, each under its own table start
      write_start('0);
      run_mix(262, MIX_SATURATE);
      settle();
      write_start(START_W'($urandom));
      run_mix(300, MIX_BALANCED);
      settle();
      write_start(START_W'($urandom));
      run_mix(230, MIX_FILL);
      settle();
      write_start({START_W{1'b1}});
      run_mix(300, MIX_DRAIN);
      settle();
      write_start(START_W'(1));
      run_mix(336, MIX_BALANCED);
      settle();

      if (mirror.awaited_answers.size() != 0)
         $display("ERROR: %0d results never arrived", mirror.awaited_answers.size());
      if (mirror.failures == 0 && mirror.awaited_answers.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
